[rtl/ngga_pkg.sv]
// ----------------------------------------------------------------------------
// ngga_pkg: shared types and constants of the GGA sentence generator
// Holds the controller/datapath command and status structs, sentence sizes
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package ngga_pkg;

    // Sentence geometry: 69 bytes, sent as 35 beats of up to two bytes
    localparam int SENT_LEN   = 69;
    localparam int PAIR_COUNT = (SENT_LEN + 1) / 2;
    localparam int PAIR_W     = $clog2(PAIR_COUNT);
    localparam int POS_W      = $clog2(SENT_LEN);

    // Binary to decimal conversion of the fractions, two bits per cycle
    localparam int FRAC_W     = 14;
    localparam int CONV_STEPS = FRAC_W / 2;
    localparam int CONV_W     = $clog2(CONV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LAT_DEG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_DEG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LON_MIN = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              start;   // take the tick, advance clock and fractions
        logic              conv;    // one conversion step of both fractions
        logic              emit;    // load the output register with one pair
        logic [PAIR_W-1:0] pair;    // pair index for emit
    } ngga_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;             // output register can take a beat
    } ngga_sts_t;

endpackage

[rtl/ngga_if.sv]
// ----------------------------------------------------------------------------
// ngga_if: valid/ready channels of the GGA sentence generator
// Tick channel carries the position jitter, char channel carries sentence
// character pairs.
// ----------------------------------------------------------------------------
interface ngga_tick_if;
    logic              valid;
    logic              ready;
    logic signed [5:0] latitude_jitter;
    logic signed [5:0] longitude_jitter;

    modport source (output valid, output latitude_jitter, output longitude_jitter,
                    input ready);
    modport sink   (input valid, input latitude_jitter, input longitude_jitter,
                    output ready);
endinterface

interface ngga_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       second_present;
    logic       last_pair;

    modport source (output valid, output first_char, output second_char,
                    output second_present, output last_pair, input ready);
    modport sink   (input valid, input first_char, input second_char,
                    input second_present, input last_pair, output ready);
endinterface

[rtl/ngga_ctrl.sv]
// ----------------------------------------------------------------------------
// ngga_ctrl: sequencer of the GGA sentence generator
// Accepts a tick, runs the fraction conversion steps, then issues one
// output beat per free output slot until the whole sentence is out.
// ----------------------------------------------------------------------------
module ngga_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  ngga_pkg::ngga_sts_t sts,
    output ngga_pkg::ngga_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [ngga_pkg::CONV_W-1:0]    conv_reg, conv_next;
    logic [ngga_pkg::PAIR_W-1:0]    pair_reg, pair_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        conv_next  = conv_reg;
        pair_next  = pair_reg;
        tick_ready = 1'b0;
        cmd        = '0;
        cmd.pair   = pair_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.start  = 1'b1;
                    conv_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (conv_reg == ngga_pkg::CONV_W'(ngga_pkg::CONV_STEPS - 1))
                begin
                    pair_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    conv_next = conv_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (pair_reg == ngga_pkg::PAIR_W'(ngga_pkg::PAIR_COUNT - 1))
                    begin
                        pair_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pair_next = pair_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            conv_reg  <= '0;
            pair_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            conv_reg  <= conv_next;
            pair_reg  <= pair_next;
        end
    end

endmodule

[rtl/ngga_dp.sv]
// ----------------------------------------------------------------------------
// ngga_dp: datapath of the GGA sentence generator
// Holds the BCD time of day, the fraction counters and their decimal form,
// the configured position digits, the running checksum and the output beat.
// ----------------------------------------------------------------------------
module ngga_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ngga_pkg::ngga_cmd_t                  cmd,
    output ngga_pkg::ngga_sts_t                  sts,
    input  logic signed [5:0]                    latitude_jitter,
    input  logic signed [5:0]                    longitude_jitter,
    input  logic                                 cfg_we,
    input  logic [ngga_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ngga_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [7:0]                           first_char,
    output logic [7:0]                           second_char,
    output logic                                 second_present,
    output logic                                 last_pair
);

    localparam logic [ngga_pkg::FRAC_W-1:0] FRAC_MAX  = 14'd9999;
    localparam logic [7:0]                  SUM_SEED  = 8'h24;   // '$' cancels itself
    localparam int                          LAST_SUM_PAIR = 31;  // pairs up to byte 63
    localparam logic [ngga_pkg::SENT_LEN*8-1:0] SENT_TEXT =
        "$GPGGA,000000,0000.0000,S,00000.0000,E,1,08,0.9,545.4,M,46.9,M,,*00\r\n";

    // Three-digit BCD of an 8-bit value
    function automatic logic [11:0] bin_to_bcd8(input logic [7:0] bin);
        logic [11:0] bcd;
        bcd = '0;
        for (int i = 7; i >= 0; i--)
        begin
            for (int d = 0; d < 3; d++)
            begin
                if (bcd[d*4 +: 4] >= 4'd5)
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
            end
            bcd = {bcd[10:0], bin[i]};
        end
        return bcd;
    endfunction

    // One shift-add-3 step of a four-digit BCD accumulator
    function automatic logic [15:0] dd_step(input logic [15:0] bcd_in, input logic bit_in);
        logic [15:0] bcd;
        bcd = bcd_in;
        for (int d = 0; d < 4; d++)
        begin
            if (bcd[d*4 +: 4] >= 4'd5)
                bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
        return {bcd[14:0], bit_in};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

    function automatic logic [7:0] dig_char(input logic [3:0] dig);
        return {4'h3, dig};
    endfunction

    function automatic logic [ngga_pkg::FRAC_W-1:0] frac_update(
        input logic [ngga_pkg::FRAC_W-1:0] frac, input logic signed [5:0] jit);
        logic signed [15:0] sum;
        sum = $signed({2'b00, frac}) + 16'(jit);
        if (sum[15])
            return '0;
        else if (sum > $signed({2'b00, FRAC_MAX}))
            return FRAC_MAX;
        else
            return sum[ngga_pkg::FRAC_W-1:0];
    endfunction

    // Time of day in BCD
    logic [1:0] hour_t_reg;
    logic [3:0] hour_u_reg;
    logic [2:0] min_t_reg, sec_t_reg;
    logic [3:0] min_u_reg, sec_u_reg;

    // Fractions and their conversion
    logic [ngga_pkg::FRAC_W-1:0] lat_frac_reg, lon_frac_reg;
    logic [ngga_pkg::FRAC_W-1:0] lat_bin_reg, lon_bin_reg;
    logic [15:0]                 lat_bcd_reg, lon_bcd_reg;
    logic [ngga_pkg::FRAC_W-1:0] lat_frac_next, lon_frac_next;

    // Configured position digits
    logic [7:0]  lat_deg_reg, lat_min_reg, lon_min_reg;
    logic [11:0] lon_deg_reg;
    logic [7:0]  cfg_val;
    logic [11:0] cfg_bcd;

    // Checksum and output beat
    logic [7:0] sum_reg;
    logic       valid_reg, present_reg, last_reg;
    logic [7:0] first_reg, second_reg;

    logic [7:0]                  sent [ngga_pkg::SENT_LEN];
    logic [ngga_pkg::POS_W-1:0]  pos0, pos1;
    logic [7:0]                  char0, char1;
    logic                        final_pair;

    assign lat_frac_next = frac_update(lat_frac_reg, latitude_jitter);
    assign lon_frac_next = frac_update(lon_frac_reg, longitude_jitter);

    // Advance time of day and update fractions on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_t_reg   <= 2'd1;
            hour_u_reg   <= 4'd2;
            min_t_reg    <= 3'd3;
            min_u_reg    <= 4'd5;
            sec_t_reg    <= 3'd1;
            sec_u_reg    <= 4'd9;
            lat_frac_reg <= 14'd9045;
            lon_frac_reg <= 14'd7642;
        end
        else if (cmd.start)
        begin
            lat_frac_reg <= lat_frac_next;
            lon_frac_reg <= lon_frac_next;
            if (sec_u_reg != 4'd9)
            begin
                sec_u_reg <= sec_u_reg + 4'd1;
            end
            else
            begin
                sec_u_reg <= 4'd0;
                if (sec_t_reg != 3'd5)
                begin
                    sec_t_reg <= sec_t_reg + 3'd1;
                end
                else
                begin
                    sec_t_reg <= 3'd0;
                    if (min_u_reg != 4'd9)
                    begin
                        min_u_reg <= min_u_reg + 4'd1;
                    end
                    else
                    begin
                        min_u_reg <= 4'd0;
                        if (min_t_reg != 3'd5)
                        begin
                            min_t_reg <= min_t_reg + 3'd1;
                        end
                        else
                        begin
                            min_t_reg <= 3'd0;
                            if (hour_t_reg == 2'd2 && hour_u_reg == 4'd3)
                            begin
                                hour_t_reg <= 2'd0;
                                hour_u_reg <= 4'd0;
                            end
                            else if (hour_u_reg == 4'd9)
                            begin
                                hour_t_reg <= hour_t_reg + 2'd1;
                                hour_u_reg <= 4'd0;
                            end
                            else
                            begin
                                hour_u_reg <= hour_u_reg + 4'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Convert both fractions to BCD, two bits a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lat_bin_reg <= lat_frac_next;
            lon_bin_reg <= lon_frac_next;
            lat_bcd_reg <= '0;
            lon_bcd_reg <= '0;
        end
        else if (cmd.conv)
        begin
            lat_bin_reg <= {lat_bin_reg[ngga_pkg::FRAC_W-3:0], 2'b00};
            lon_bin_reg <= {lon_bin_reg[ngga_pkg::FRAC_W-3:0], 2'b00};
            lat_bcd_reg <= dd_step(dd_step(lat_bcd_reg, lat_bin_reg[ngga_pkg::FRAC_W-1]),
                                   lat_bin_reg[ngga_pkg::FRAC_W-2]);
            lon_bcd_reg <= dd_step(dd_step(lon_bcd_reg, lon_bin_reg[ngga_pkg::FRAC_W-1]),
                                   lon_bin_reg[ngga_pkg::FRAC_W-2]);
        end
    end

    // Mask configuration data to the register width
    always_comb
    begin
        unique case (cfg_index)
            ngga_pkg::REG_LAT_DEG: cfg_val = {1'b0, cfg_data[6:0]};
            ngga_pkg::REG_LAT_MIN: cfg_val = {2'b00, cfg_data[5:0]};
            ngga_pkg::REG_LON_DEG: cfg_val = cfg_data;
            ngga_pkg::REG_LON_MIN: cfg_val = {2'b00, cfg_data[5:0]};
            default:               cfg_val = cfg_data;
        endcase
    end

    assign cfg_bcd = bin_to_bcd8(cfg_val);

    // Store configured values as decimal digits; longitude degrees keep three, the others two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_deg_reg <= 8'h35;
            lat_min_reg <= 8'h18;
            lon_deg_reg <= 12'h149;
            lon_min_reg <= 8'h07;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ngga_pkg::REG_LAT_DEG: lat_deg_reg <= cfg_bcd[7:0];
                ngga_pkg::REG_LAT_MIN: lat_min_reg <= cfg_bcd[7:0];
                ngga_pkg::REG_LON_DEG: lon_deg_reg <= cfg_bcd;
                ngga_pkg::REG_LON_MIN: lon_min_reg <= cfg_bcd[7:0];
                default: ;
            endcase
        end
    end

    // Assemble the sentence characters
    always_comb
    begin
        for (int i = 0; i < ngga_pkg::SENT_LEN; i++)
            sent[i] = SENT_TEXT[(ngga_pkg::SENT_LEN - 1 - i)*8 +: 8];
        sent[7]  = dig_char({2'b00, hour_t_reg});
        sent[8]  = dig_char(hour_u_reg);
        sent[9]  = dig_char({1'b0, min_t_reg});
        sent[10] = dig_char(min_u_reg);
        sent[11] = dig_char({1'b0, sec_t_reg});
        sent[12] = dig_char(sec_u_reg);
        sent[14] = dig_char(lat_deg_reg[7:4]);
        sent[15] = dig_char(lat_deg_reg[3:0]);
        sent[16] = dig_char(lat_min_reg[7:4]);
        sent[17] = dig_char(lat_min_reg[3:0]);
        sent[19] = dig_char(lat_bcd_reg[15:12]);
        sent[20] = dig_char(lat_bcd_reg[11:8]);
        sent[21] = dig_char(lat_bcd_reg[7:4]);
        sent[22] = dig_char(lat_bcd_reg[3:0]);
        sent[26] = dig_char(lon_deg_reg[11:8]);
        sent[27] = dig_char(lon_deg_reg[7:4]);
        sent[28] = dig_char(lon_deg_reg[3:0]);
        sent[29] = dig_char(lon_min_reg[7:4]);
        sent[30] = dig_char(lon_min_reg[3:0]);
        sent[32] = dig_char(lon_bcd_reg[15:12]);
        sent[33] = dig_char(lon_bcd_reg[11:8]);
        sent[34] = dig_char(lon_bcd_reg[7:4]);
        sent[35] = dig_char(lon_bcd_reg[3:0]);
        sent[65] = hex_char(sum_reg[7:4]);
        sent[66] = hex_char(sum_reg[3:0]);
    end

    assign final_pair = (cmd.pair == ngga_pkg::PAIR_W'(ngga_pkg::PAIR_COUNT - 1));
    assign pos0       = {cmd.pair, 1'b0};
    assign pos1       = {cmd.pair, 1'b1};
    assign char0      = sent[pos0];
    assign char1      = final_pair ? 8'h00 : sent[pos1];

    // Fold emitted bytes into the checksum up to the '*'
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            sum_reg <= SUM_SEED;
        else if (cmd.emit && cmd.pair <= ngga_pkg::PAIR_W'(LAST_SUM_PAIR))
            sum_reg <= sum_reg ^ char0 ^ char1;
    end

    // Output register: load a beat when free, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            first_reg   <= char0;
            second_reg  <= char1;
            present_reg <= !final_pair;
            last_reg    <= final_pair;
        end
    end

    assign sts.out_free   = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign first_char     = first_reg;
    assign second_char    = second_reg;
    assign second_present = present_reg;
    assign last_pair      = last_reg;

endmodule

[rtl/nmea_gga_sentence_generator.sv]
// After a tick beat is accepted, the sequencer runs the fraction-to-decimal conversion
// steps in ST_CONV, then sends the 35 pair beats through the single output register in
// ST_EMIT; a new tick is accepted only in ST_IDLE, once the last pair is loaded. Sink
// stalls hold the pair beats in ST_EMIT.
// Reset (rst_n low, asynchronous): sequencer idle, output empty, time 12:35:19,
// fractions 9045/7642, configuration 35, 18, 149, 7.
// ----------------------------------------------------------------------------
// nmea_gga_sentence_generator: GGA sentence generator top level
// Takes one jitter tick per second and emits a 69-byte GGA sentence as
// 35 character-pair beats.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    ngga_tick_if.sink                         tick,
    ngga_char_if.source                       chars,
    input  logic                              cfg_we,
    input  logic [ngga_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ngga_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ngga_pkg::ngga_cmd_t cmd;
    ngga_pkg::ngga_sts_t sts;

    // Sequencer
    ngga_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath
    ngga_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .latitude_jitter  (tick.latitude_jitter),
        .longitude_jitter (tick.longitude_jitter),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_ready        (chars.ready),
        .out_valid        (chars.valid),
        .first_char       (chars.first_char),
        .second_char      (chars.second_char),
        .second_present   (chars.second_present),
        .last_pair        (chars.last_pair)
    );

endmodule
